[rtl/core/ptwrl_pkg.sv]
`default_nettype none
package ptwrl_pkg;
    localparam int unsigned ENTRIES_DEF    = 1024;
    localparam int unsigned TOKEN_BITS_DEF = 128;
    localparam int unsigned CFG_IDX_W      = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_REQ    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'b1;
    localparam logic [15:0] WINDOW_LEN_RST = 16'd1000;

    // Request as queued between the front and the back.
    typedef struct packed {
        logic [63:0] tok_hi;
        logic [63:0] tok_lo;
        logic [63:0] now;
        logic        bypass;
    } t_req;
endpackage
`default_nettype wire

[rtl/core/ptwrl_front.sv]
`default_nettype none
// Accepts requests, masks the token to its width, marks bypass when the
// limit is zero, and queues them for the back end.
module ptwrl_front #(
    parameter int unsigned TOKEN_BITS = ptwrl_pkg::TOKEN_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [63:0]        i_token_hi,
    input  wire logic [63:0]        i_token_lo,
    input  wire logic [63:0]        i_now_ms,
    input  wire logic [15:0]        i_max_req,
    output logic                    o_req_valid,
    output ptwrl_pkg::t_req         o_req,
    input  wire logic               i_req_take
);
    localparam int unsigned LO_BITS = (TOKEN_BITS >= 64) ? 64 : TOKEN_BITS;
    localparam int unsigned HI_BITS = (TOKEN_BITS > 64) ? TOKEN_BITS - 64 : 0;
    localparam logic [63:0] LO_MASK = (LO_BITS == 64) ? '1 : ((64'd1 << LO_BITS) - 64'd1);
    localparam logic [63:0] HI_MASK = (HI_BITS == 64) ? '1 :
                                      ((HI_BITS == 0) ? '0 : ((64'd1 << HI_BITS) - 64'd1));

    ptwrl_pkg::t_req r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            w_push, w_pop;
    ptwrl_pkg::t_req w_in;

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_req_valid = (r_cnt != 2'd0);
    assign w_pop       = i_req_take && o_req_valid;
    assign o_req       = r_q[r_rp];

    always_comb begin
        w_in.tok_hi = i_token_hi & HI_MASK;
        w_in.tok_lo = i_token_lo & LO_MASK;
        w_in.now    = i_now_ms;
        w_in.bypass = (i_max_req == 16'd0);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

[rtl/core/ptwrl_back.sv]
`default_nettype none
// For a limited request, scans the slot table one entry per cycle for hit,
// first free slot and oldest start, then does one read-modify-write of the chosen slot.
module ptwrl_back #(
    parameter int unsigned ENTRIES = ptwrl_pkg::ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    input  ptwrl_pkg::t_req  i_req,
    output logic             o_req_take,
    input  wire logic [15:0] i_max_req,
    input  wire logic [15:0] i_win_len,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_allowed,
    output logic             o_busy
);
    localparam int unsigned IW = $clog2(ENTRIES);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLEAR = 6'b000010,
        S_SCAN  = 6'b000100,
        S_READ  = 6'b001000,
        S_WRITE = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    logic [127:0] r_tok_mem [ENTRIES];
    logic [63:0]  r_start_mem [ENTRIES];
    logic [15:0]  r_cnt_mem [ENTRIES];
    logic         r_val_mem [ENTRIES];

    t_state       r_state;
    logic [IW:0]  r_idx;
    logic [IW-1:0] r_rd_addr;
    logic [127:0] r_rd_tok;
    logic [63:0]  r_rd_start;
    logic [15:0]  r_rd_cnt;
    logic         r_rd_val;
    logic         r_rd_live;
    logic [IW-1:0] r_rd_i;
    logic         r_hit, r_have_free, r_have_old;
    logic [IW-1:0] r_hit_i, r_free_i, r_old_i;
    logic [63:0]  r_old_ms;
    ptwrl_pkg::t_req r_req;
    logic         r_allowed;
    logic         r_val_we;
    logic         r_val_wd;
    logic [IW-1:0] r_sel;

    logic         w_match;
    logic [63:0]  w_end;
    logic         w_restart;
    logic [15:0]  w_cnt;
    logic [63:0]  w_start;
    logic         w_more;

    assign o_req_take = (r_state == S_IDLE) && i_req_valid;
    assign o_valid    = (r_state == S_OUT);
    assign o_allowed  = r_allowed;
    assign o_busy     = (r_state != S_IDLE);

    assign w_match = r_rd_val && (r_rd_tok == {r_req.tok_hi, r_req.tok_lo});
    assign w_end   = r_rd_start + {48'd0, i_win_len};
    assign w_restart = !r_hit || (r_req.now >= w_end);
    assign w_cnt   = w_restart ? 16'd0 : r_rd_cnt;
    assign w_start = w_restart ? r_req.now : r_rd_start;
    assign w_more  = (r_idx < (IW+1)'(ENTRIES));

    // Read port: scanning address, or the hit slot.
    always_ff @(posedge i_clk) begin
        r_rd_tok   <= r_tok_mem[r_rd_addr];
        r_rd_start <= r_start_mem[r_rd_addr];
        r_rd_cnt   <= r_cnt_mem[r_rd_addr];
        r_rd_val   <= r_val_mem[r_rd_addr];
    end

    // The valid store is cleared by a sweep after reset.
    always_ff @(posedge i_clk) begin
        if (r_val_we) r_val_mem[r_sel] <= r_val_wd;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE && r_idx != '0 && !r_req.bypass) begin
            if (!r_hit) r_tok_mem[r_sel] <= {r_req.tok_hi, r_req.tok_lo};
            r_start_mem[r_sel] <= w_start;
            r_cnt_mem[r_sel]   <= (w_cnt < i_max_req) ? w_cnt + 16'd1 : w_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_idx     <= '0;
            r_rd_addr <= '0;
            r_rd_live <= 1'b0;
            r_val_we  <= 1'b0;
            r_val_wd  <= 1'b0;
            r_sel     <= '0;
        end else begin
            r_val_we <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_val_we <= 1'b1;
                    r_val_wd <= 1'b0;
                    r_sel    <= r_idx[IW-1:0];
                    if (r_idx == (IW+1)'(ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                        r_idx <= '0;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req <= i_req;
                        r_hit <= 1'b0;
                        r_have_free <= 1'b0;
                        r_have_old  <= 1'b0;
                        r_old_ms    <= '1;
                        r_idx <= '0;
                        r_rd_addr <= '0;
                        r_rd_live <= 1'b0;
                        if (i_req.bypass) begin
                            r_allowed <= 1'b1;
                            r_state   <= S_OUT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // Issue addresses while r_idx < ENTRIES; evaluate the
                    // registered data of the previous address.
                    if (w_more) begin
                        r_rd_i    <= r_rd_addr;
                        r_rd_live <= 1'b1;
                        r_idx     <= r_idx + 1'b1;
                        r_rd_addr <= r_rd_addr + 1'b1;
                    end else begin
                        r_rd_live <= 1'b0;
                    end
                    if (r_rd_live && !r_hit) begin
                        if (!r_rd_val) begin
                            if (!r_have_free) begin
                                r_have_free <= 1'b1;
                                r_free_i <= r_rd_i;
                            end
                        end else if (w_match) begin
                            r_hit <= 1'b1;
                            r_hit_i <= r_rd_i;
                        end else if (!r_have_old || r_rd_start < r_old_ms) begin
                            r_have_old <= 1'b1;
                            r_old_ms <= r_rd_start;
                            r_old_i  <= r_rd_i;
                        end
                    end
                    if ((r_rd_live && !r_hit && r_rd_val && w_match) ||
                        (!r_rd_live && !w_more)) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (r_hit) r_sel <= r_hit_i;
                    else if (r_have_free) r_sel <= r_free_i;
                    else r_sel <= r_old_i;
                    if (r_hit) r_rd_addr <= r_hit_i;
                    r_idx <= '0;
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    // r_idx marks whether the slot read has landed.
                    if (r_idx == '0) begin
                        r_idx <= (IW+1)'(1);
                    end else begin
                        r_allowed <= (w_cnt < i_max_req);
                        r_val_we <= 1'b1;
                        r_val_wd <= 1'b1;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/core/per_token_window_rate_limiter.sv]
`default_nettype none
// Channel   Direction  Handshake           Payload
// request   in         i_valid / o_stall   i_token_hi, i_token_lo, i_now_ms
// result    out        o_valid / i_stall   o_allowed
// config    in         i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// A limited request holds the back end while it is taken from the queue, the
// slot table is scanned through one read port, the slot is picked, the slot is
// read, modified and written, and the result is handed off. A hit ends the
// scan early. With the limit at zero a request skips the scan and the slot
// table. After reset, a clearing pass resets the valid bits; requests queue
// meanwhile. A two-entry queue parts the front from the back; a result stall
// fills it and raises o_stall.
module per_token_window_rate_limiter #(
    parameter int unsigned ENTRIES    = ptwrl_pkg::ENTRIES_DEF,
    parameter int unsigned TOKEN_BITS = ptwrl_pkg::TOKEN_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [63:0] i_token_hi,
    input  wire logic [63:0] i_token_lo,
    input  wire logic [63:0] i_now_ms,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_allowed,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [ptwrl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    logic [15:0]     r_max_req, r_win_len;
    logic            w_req_valid, w_req_take, w_busy;
    ptwrl_pkg::t_req w_req;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_req <= '0;
            r_win_len <= ptwrl_pkg::WINDOW_LEN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ptwrl_pkg::REG_MAX_REQ:    r_max_req <= i_cfg_data;
                ptwrl_pkg::REG_WINDOW_LEN: r_win_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ptwrl_front #(.TOKEN_BITS(TOKEN_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_token_hi(i_token_hi), .i_token_lo(i_token_lo), .i_now_ms(i_now_ms),
        .i_max_req(r_max_req),
        .o_req_valid(w_req_valid), .o_req(w_req), .i_req_take(w_req_take)
    );

    ptwrl_back #(.ENTRIES(ENTRIES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(w_req_valid), .i_req(w_req), .o_req_take(w_req_take),
        .i_max_req(r_max_req), .i_win_len(r_win_len),
        .o_valid(o_valid), .i_stall(i_stall), .o_allowed(o_allowed),
        .o_busy(w_busy)
    );

    a_stable_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_allowed))
        else $error("result changed while stalled");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_take |-> !o_valid)
        else $error("request taken while a result waits");
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> w_busy)
        else $error("result without work in progress");
endmodule
`default_nettype wire

[tb/per_token_window_rate_limiter_tb.sv]
`timescale 1ns / 1ps
module per_token_window_rate_limiter_tb;

    localparam int unsigned NSLOT = ptwrl_pkg::ENTRIES_DEF;
    localparam longint unsigned CYCLE_LIMIT = 64'd8_000_000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic [63:0] i_token_hi;
    logic [63:0] i_token_lo;
    logic [63:0] i_now_ms;
    logic o_valid;
    logic i_stall;
    logic o_allowed;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [ptwrl_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0] i_cfg_data;

    per_token_window_rate_limiter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_token_hi(i_token_hi), .i_token_lo(i_token_lo), .i_now_ms(i_now_ms),
        .o_valid(o_valid), .i_stall(i_stall), .o_allowed(o_allowed),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Shadow copy of the limiter's registers and slot table.
    logic [15:0] lim_max;
    logic [15:0] lim_window;
    logic        tbl_valid [NSLOT];
    logic [63:0] tbl_hi    [NSLOT];
    logic [63:0] tbl_lo    [NSLOT];
    logic [63:0] tbl_start [NSLOT];
    logic [15:0] tbl_count [NSLOT];

    logic admit_expected[$];
    int unsigned mismatches;
    longint unsigned cycles;
    int unsigned stall_hold;
    logic [63:0] clock_ms;
    logic [63:0] pool_hi [8];
    logic [63:0] pool_lo [8];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic predict_admit(input logic [63:0] hi, input logic [63:0] lo,
                                           input logic [63:0] now);
        int slot;
        int free_slot;
        int old_slot;
        logic [63:0] old_start;
        logic found;
        if (lim_max == 16'd0) return 1'b1;
        found = 1'b0;
        free_slot = -1;
        old_slot = 0;
        old_start = '1;
        slot = 0;
        for (int k = 0; k < NSLOT && !found; k++) begin
            if (!tbl_valid[k]) begin
                if (free_slot < 0) free_slot = k;
            end else if (tbl_hi[k] == hi && tbl_lo[k] == lo) begin
                found = 1'b1;
                slot = k;
            end else if (tbl_start[k] < old_start) begin
                old_start = tbl_start[k];
                old_slot = k;
            end
        end
        if (found) begin
            if (now >= tbl_start[slot] + 64'(lim_window)) begin
                tbl_start[slot] = now;
                tbl_count[slot] = 16'd0;
            end
        end else begin
            slot = (free_slot >= 0) ? free_slot : old_slot;
            tbl_valid[slot] = 1'b1;
            tbl_hi[slot] = hi;
            tbl_lo[slot] = lo;
            tbl_start[slot] = now;
            tbl_count[slot] = 16'd0;
        end
        if (tbl_count[slot] >= lim_max) return 1'b0;
        tbl_count[slot] = tbl_count[slot] + 16'd1;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    // Called at a rising edge; returns at the edge of the transfer, or after the random idle gap that follows it.
    task automatic send_request(input logic [63:0] hi, input logic [63:0] lo,
                                input logic [63:0] now);
        int unsigned gap;
        i_valid <= 1'b1;
        i_token_hi <= hi;
        i_token_lo <= lo;
        i_now_ms <= now;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        admit_expected.push_back(predict_admit(hi, lo, now));
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (admit_expected.size() != 0) @(posedge i_clk);
        repeat (NSLOT + 20) @(posedge i_clk);
    endtask

    // Leaves i_cfg_valid high; the caller drops it after its last write.
    task automatic write_reg(input logic [ptwrl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == ptwrl_pkg::REG_MAX_REQ) lim_max = val;
        else lim_window = val;
    endtask

    task automatic set_limits(input logic [15:0] max_req, input logic [15:0] win);
        wait_idle();
        write_reg(ptwrl_pkg::REG_MAX_REQ, max_req);
        write_reg(ptwrl_pkg::REG_WINDOW_LEN, win);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        logic [63:0] top;
        top = '1;
        // Limiting off at reset: everything passes and nothing is stored.
        send_request(top, top, top);
        send_request('0, '0, '0);
        set_limits(16'd2, 16'd1);
        send_request(top, top, 64'd100);
        send_request(top, top, 64'd100);
        send_request(top, top, 64'd100);
        send_request(top, top, 64'd101);
        send_request(top, top, 64'd50);
        send_request('0, '0, 64'd7);
        send_request('0, 64'd1, 64'd7);
        send_request(64'd1, '0, 64'd7);
        send_request('0, '0, 64'd7);
        send_request('0, '0, 64'd7);
        // Start near the top of the time range so start plus length wraps.
        set_limits(16'd1, 16'd10);
        send_request(64'h5a, 64'ha5, top - 64'd5);
        send_request(64'h5a, 64'ha5, top - 64'd3);
        send_request(64'h5a, 64'ha5, 64'd2);
        send_request(64'h5a, 64'ha5, 64'd3);
        set_limits(16'd65535, 16'd65535);
        send_request(top, '0, top);
        send_request(top, '0, top);
        send_request('0, top, '0);
        set_limits(16'd0, 16'd1);
        send_request(64'h5a, 64'ha5, 64'd2);
    endtask

    // Many distinct tokens with few distinct start times, so that free
    // slots are taken in order, one per request, across about a tenth of the table.
    task automatic test_allocation();
        set_limits(16'd1, 16'd65535);
        for (int n = 0; n < 100; n++)
            send_request(rand64(), rand64(), 64'($urandom_range(0, 40)));
    endtask

    task automatic run_phase(input logic [15:0] max_req, input logic [15:0] win,
                             input int unsigned count);
        int unsigned p;
        set_limits(max_req, win);
        for (int n = 0; n < count; n++) begin
            p = $urandom_range(0, 7);
            if ($urandom_range(0, 9) == 0) begin
                send_request(rand64(), rand64(), rand64());
            end else begin
                if ($urandom_range(0, 19) == 0) clock_ms = clock_ms - 64'($urandom_range(0, 30));
                else clock_ms = clock_ms + 64'($urandom_range(0, 2 * win + 1) / 3);
                send_request(pool_hi[p], pool_lo[p], clock_ms);
            end
        end
    endtask

    task automatic test_random();
        for (int k = 0; k < 8; k++) begin
            pool_hi[k] = rand64();
            pool_lo[k] = rand64();
        end
        clock_ms = rand64();
        run_phase(16'd3, 16'd20, 70);
        run_phase(16'd1, 16'd1, 60);
        run_phase(16'd0, 16'd5, 150);
        run_phase(16'($urandom_range(2, 6)), 16'($urandom_range(2, 40)), 70);
        clock_ms = 64'hffff_ffff_ffff_ff00;
        run_phase(16'd2, 16'd65535, 50);
        run_phase(16'd65535, 16'd8, 40);
    endtask

    // Result side: random stall pattern, checking, and the cycle limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            i_stall <= ($urandom_range(0, 3) == 0);
            stall_hold <= pick_gap();
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (admit_expected.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else if (o_allowed !== admit_expected[0]) begin
                report_mismatch($sformatf("allowed %b, expected %b",
                                          o_allowed, admit_expected[0]));
                void'(admit_expected.pop_front());
            end else begin
                void'(admit_expected.pop_front());
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_token_hi = '0;
        i_token_lo = '0;
        i_now_ms = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = ptwrl_pkg::REG_MAX_REQ;
        i_cfg_data = '0;
        mismatches = 0;
        cycles = 0;
        stall_hold = 0;
        lim_max = 16'd0;
        lim_window = ptwrl_pkg::WINDOW_LEN_RST;
        for (int k = 0; k < NSLOT; k++) tbl_valid[k] = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_allocation();
        test_random();
        wait_idle();
        if (admit_expected.size() != 0)
            report_mismatch("results still outstanding");
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
